/* rtl/bsog_pkg.sv */
package bsog_pkg;

  // channel states
  localparam logic [2:0] ModeOff   = 3'd0;
  localparam logic [2:0] ModeCheck = 3'd1;
  localparam logic [2:0] ModeOn    = 3'd2;
  localparam logic [2:0] ModeShort = 3'd3;
  localparam logic [2:0] ModeOvc   = 3'd4;

  // configuration register indexes
  localparam logic [1:0] RegScale    = 2'd0;
  localparam logic [1:0] RegLimit    = 2'd1;
  localparam logic [1:0] RegOvcTime  = 2'd2;
  localparam logic [1:0] RegRetry    = 2'd3;

  // bits of the pin latch
  localparam int unsigned PinDrvP = 0;
  localparam int unsigned PinDrvN = 1;
  localparam int unsigned PinSenP = 2;
  localparam int unsigned PinSenN = 3;

  localparam logic [11:0] ShortRawLimit = 12'd3103;

  // raw * scale / 1000 by reciprocal, exact for products below 2^28
  localparam longint unsigned MaDivisor  = 1000;
  localparam int unsigned     RecipShift = 38;
  localparam logic [28:0]     RecipMult  =
    29'(((64'd1 << RecipShift) + MaDivisor - 64'd1) / MaDivisor);

  localparam logic [15:0] ScaleReset    = 16'd1000;
  localparam logic [18:0] LimitReset    = 19'd10000;
  localparam logic [31:0] OvcTimeReset  = 32'd100;
  localparam logic [31:0] RetryReset    = 32'd0;

  typedef struct packed {
    logic [15:0] sense_gain;
    logic [18:0] current_limit_ma;
    logic [31:0] overcurrent_time_ms;
    logic [31:0] retry_lock_ms;
  } cfg_t;

  typedef struct packed {
    logic [31:0]        time_ms;
    logic [11:0]        raw_current;
    logic               set_enable;
    logic signed [1:0]  enable_request;
  } item_t;

endpackage

/* rtl/bsog_step.sv */
module bsog_step (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 upd_i,
  input  bsog_pkg::item_t      item_i,
  input  logic [18:0]          cur_ma_i,
  input  bsog_pkg::cfg_t       cfg_i,
  output logic [3:0]           pins_o,
  output logic [18:0]          current_o,
  output logic [2:0]           mode_o
);
  import bsog_pkg::*;

  logic [2:0]  mode_q, mode_d, mode_a;
  logic [31:0] mark_q, mark_d, mark_on;
  logic [1:0]  dir_q, dir_d;
  logic [18:0] cur_q, cur_d;
  logic [3:0]  pins_q, pins_d;
  logic        dir_pos;
  logic [31:0] on_elapsed, fault_elapsed;

  always_comb begin
    dir_d = dir_q;
    if (item_i.set_enable && (dir_q == 2'b00 || item_i.enable_request == 2'sb00)) begin
      dir_d = item_i.enable_request;
    end
    dir_pos = (dir_d == 2'b01);

    mode_a = (dir_d == 2'b00) ? ModeOff : mode_q;
    cur_d  = (dir_d == 2'b00) ? '0 : cur_q;
    pins_d = pins_q;
    mark_d = mark_q;
    mode_d = mode_a;

    mark_on       = mark_q;
    on_elapsed    = '0;
    fault_elapsed = item_i.time_ms - mark_q;

    if (mode_a != ModeOff && mode_a <= ModeOvc) begin
      if (dir_pos) begin
        pins_d[PinSenP] = 1'b1;
      end else begin
        pins_d[PinSenN] = 1'b1;
      end
    end

    case (mode_a)
      ModeCheck: begin
        mark_d = item_i.time_ms;
        if (dir_pos) begin
          pins_d[PinDrvP] = 1'b1;
        end else begin
          pins_d[PinDrvN] = 1'b1;
        end
        mode_d = ModeOn;
      end
      ModeOn: begin
        cur_d = cur_ma_i;
        // below the limit the overcurrent timer restarts; a short restarts it too
        if (cur_ma_i < cfg_i.current_limit_ma || item_i.raw_current > ShortRawLimit) begin
          mark_on = item_i.time_ms;
        end
        mark_d     = mark_on;
        on_elapsed = item_i.time_ms - mark_on;
        if (item_i.raw_current > ShortRawLimit) begin
          pins_d[PinDrvP] = 1'b0;
          pins_d[PinDrvN] = 1'b0;
          mode_d          = ModeShort;
        end
        if (on_elapsed > cfg_i.overcurrent_time_ms) begin
          mark_d          = item_i.time_ms;
          pins_d[PinDrvP] = 1'b0;
          pins_d[PinDrvN] = 1'b0;
          mode_d          = ModeOvc;
        end
      end
      ModeShort, ModeOvc: begin
        if (cfg_i.retry_lock_ms != 32'd0 && fault_elapsed > cfg_i.retry_lock_ms) begin
          mark_d = item_i.time_ms;
          if (dir_pos) begin
            pins_d[PinDrvP] = 1'b1;
          end else begin
            pins_d[PinDrvN] = 1'b1;
          end
          mode_d = ModeOn;
        end
      end
      default: begin
        mode_d = ModeOff;
        pins_d = '0;
        if (dir_d != 2'b00) begin
          mark_d = item_i.time_ms;
          mode_d = ModeCheck;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeOff;
      mark_q <= '0;
      dir_q  <= '0;
      cur_q  <= '0;
      pins_q <= '0;
    end else if (upd_i) begin
      mode_q <= mode_d;
      mark_q <= mark_d;
      dir_q  <= dir_d;
      cur_q  <= cur_d;
      pins_q <= pins_d;
    end
  end

  assign pins_o    = pins_q;
  assign current_o = cur_q;
  assign mode_o    = mode_q;

endmodule

/* rtl/bidirectional_switch_overcurrent_guard.sv */
// Overcurrent guard for a two-direction high-side switch, one poll per input beat.
// Input channel (in_valid_i/in_ready_o): time stamp in ms, raw 12-bit current
// sample, optional direction request. Output channel (out_valid_o/out_ready_i):
// drive and sense enables, load current in mA and the channel state after the poll.
// Config channel (cfg_valid_i/cfg_ready_o): register index and data, always ready;
// write only while no poll is in flight.
// Stages: input register, raw*scale product, reciprocal multiply for the /1000,
// then the state update that loads the result register. One multiply per middle stage.
// Throughput: one poll per cycle unless the receiver stalls; the update is one step.
// When the receiver stalls, beats queue in the pipeline stages (up to four held)
// and in_ready_o drops only once every stage is full.
// Reset clears the pipeline, the channel state (off, pins low, current 0) and
// loads the register defaults: scale 1000, limit 10000 mA, 100 ms, no retry.
module bidirectional_switch_overcurrent_guard (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [31:0]        time_ms_i,
  input  logic [11:0]        raw_current_i,
  input  logic               set_enable_i,
  input  logic signed [1:0]  enable_request_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               drive_pos_o,
  output logic               drive_neg_o,
  output logic               sense_pos_o,
  output logic               sense_neg_o,
  output logic [18:0]        load_current_ma_o,
  output logic [2:0]         channel_state_o
);
  import bsog_pkg::*;

  cfg_t        cfg_q;
  item_t       s1_q, s2_q, s3_q;
  logic        v1_q, v2_q, v3_q, vo_q;
  logic        r1, r2, r3, go_out;
  logic [27:0] prod_d, prod_q;
  logic [56:0] recip_wide;
  logic [18:0] cur_q;
  logic [3:0]  pins;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sense_gain          <= ScaleReset;
      cfg_q.current_limit_ma    <= LimitReset;
      cfg_q.overcurrent_time_ms <= OvcTimeReset;
      cfg_q.retry_lock_ms       <= RetryReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegScale:   cfg_q.sense_gain          <= cfg_data_i[15:0];
        RegLimit:   cfg_q.current_limit_ma    <= cfg_data_i[18:0];
        RegOvcTime: cfg_q.overcurrent_time_ms <= cfg_data_i;
        RegRetry:   cfg_q.retry_lock_ms       <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // each stage moves when the one after it frees up
  assign go_out     = !vo_q || out_ready_i;
  assign r3         = !v3_q || go_out;
  assign r2         = !v2_q || r3;
  assign r1         = !v1_q || r2;
  assign in_ready_o = r1;

  assign prod_d     = {16'd0, s1_q.raw_current} * {12'd0, cfg_q.sense_gain};
  assign recip_wide = {29'd0, prod_q} * {28'd0, RecipMult};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (r1) v1_q <= in_valid_i;
      if (r2) v2_q <= v1_q;
      if (r3) v3_q <= v2_q;
      if (go_out) vo_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (r1) begin
      s1_q.time_ms        <= time_ms_i;
      s1_q.raw_current    <= raw_current_i;
      s1_q.set_enable     <= set_enable_i;
      s1_q.enable_request <= enable_request_i;
    end
    if (r2) begin
      s2_q   <= s1_q;
      prod_q <= prod_d;
    end
    if (r3) begin
      s3_q  <= s2_q;
      cur_q <= recip_wide[RecipShift +: 19];
    end
  end

  bsog_step u_step (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .upd_i     (v3_q && go_out),
    .item_i    (s3_q),
    .cur_ma_i  (cur_q),
    .cfg_i     (cfg_q),
    .pins_o    (pins),
    .current_o (load_current_ma_o),
    .mode_o    (channel_state_o)
  );

  assign out_valid_o = vo_q;
  assign drive_pos_o = pins[PinDrvP];
  assign drive_neg_o = pins[PinDrvN];
  assign sense_pos_o = pins[PinSenP];
  assign sense_neg_o = pins[PinSenN];

endmodule

/* rtl/bsog_checker.sv */
module bsog_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               out_valid_o,
  input  logic               out_ready_i,
  input  logic               drive_pos_o,
  input  logic               drive_neg_o,
  input  logic               sense_pos_o,
  input  logic               sense_neg_o,
  input  logic [18:0]        load_current_ma_o,
  input  logic [2:0]         channel_state_o
);
  import bsog_pkg::*;

  // both directions are never driven at once
  a_one_drive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(drive_pos_o && drive_neg_o))
    else $error("both drive enables high");

  // the switch is driven exactly while the channel is on
  a_drive_on: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((drive_pos_o || drive_neg_o) == (channel_state_o == ModeOn)))
    else $error("drive enables disagree with channel state");

  // an off channel shows no pins and no current
  a_off_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && channel_state_o == ModeOff |->
      !drive_pos_o && !drive_neg_o && !sense_pos_o && !sense_neg_o &&
      load_current_ma_o == 19'd0)
    else $error("off channel with pins or current set");

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(channel_state_o) &&
      $stable(load_current_ma_o) && $stable(drive_pos_o) && $stable(drive_neg_o))
    else $error("stalled result beat changed");

endmodule

bind bidirectional_switch_overcurrent_guard bsog_checker u_bsog_checker (.*);
